@@ sv/cip_pkg.sv @@
// Package for the checked integer text parser: shared types, status codes,
// character constants and width helper functions. No dependencies.
`default_nettype none
package cip_pkg;

  // Result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_INVALID   = 3'd2;
  localparam logic [2:0] ST_OVERFLOW  = 3'd3;
  localparam logic [2:0] ST_UNDERFLOW = 3'd4;

  // Target width codes
  localparam logic [1:0] WC_8  = 2'd0;
  localparam logic [1:0] WC_16 = 2'd1;
  localparam logic [1:0] WC_32 = 2'd2;
  localparam logic [1:0] WC_64 = 2'd3;

  // ASCII characters of interest
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  // Saturation limits of the position and hex digit counters
  localparam logic [1:0] POS_MAX  = 2'd3;
  localparam logic [4:0] HCNT_MAX = 5'd17;

  // One classified character request, as it sits in the queue
  typedef struct packed {
    logic       empty;
    logic       last;
    logic [1:0] width_code;
    logic       signed_type;
    logic       hex;
    logic       is_digit;
    logic       is_nib;
    logic [3:0] nib;
    logic       is_minus;
    logic       is_zero;
    logic       is_x;
  } cip_item_t;

  // Token summary handed from the execute stage to the finish stage
  typedef struct packed {
    logic        empty;
    logic        hex;
    logic [1:0]  width_code;
    logic        signed_type;
    logic [63:0] acc;
    logic [1:0]  pos;
    logic        neg;
    logic        inv;
    logic        ovf;
    logic [4:0]  hcnt;
    logic        pfault;
  } cip_fin_t;

  // Unsigned maximum of the target width
  function automatic logic [63:0] cip_umax(input logic [1:0] wc);
    logic [63:0] m;
    case (wc)
      WC_8:    m = 64'h0000_0000_0000_00FF;
      WC_16:   m = 64'h0000_0000_0000_FFFF;
      WC_32:   m = 64'h0000_0000_FFFF_FFFF;
      default: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

  // Most hex digits the target width holds
  function automatic logic [4:0] cip_hex_limit(input logic [1:0] wc);
    logic [4:0] n;
    case (wc)
      WC_8:    n = 5'd2;
      WC_16:   n = 5'd4;
      WC_32:   n = 5'd8;
      default: n = 5'd16;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

@@ sv/cip_front.sv @@
// Front end of the text parser: holds the mode register, classifies each
// character request and pushes it into the queue. Uses cip_pkg.
`default_nettype none
module cip_front
  import cip_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_hex_mode,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_ch,
  input  wire logic       in_last_char,
  input  wire logic       in_empty_token,
  input  wire logic [1:0] in_width_code,
  input  wire logic       in_signed_type,
  input  wire logic       q_full,
  output logic            q_push,
  output cip_item_t       q_item
);

  logic       hex_mode_r;
  logic       hex_mode_nxt;
  logic [7:0] off_d;
  logic [7:0] off_l;
  logic [7:0] off_u;
  logic       is_lo;
  logic       is_up;

  // Take mode writes at any time
  assign cfg_ready    = 1'b1;
  assign hex_mode_nxt = (cfg_valid && cfg_ready) ? cfg_hex_mode : hex_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hex_mode_r <= 1'b0;
    end else begin
      hex_mode_r <= hex_mode_nxt;
    end
  end

  // Accept whenever the queue has room
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // Classify the character and tag it with the current mode
  always_comb begin
    off_d = in_ch - CH_ZERO;
    off_l = in_ch - CH_LA;
    off_u = in_ch - CH_UA;
    is_lo = (in_ch >= CH_LA) && (in_ch <= CH_LF);
    is_up = (in_ch >= CH_UA) && (in_ch <= CH_UF);

    q_item.empty       = in_empty_token;
    q_item.last        = in_last_char;
    q_item.width_code  = in_width_code;
    q_item.signed_type = in_signed_type;
    q_item.hex         = hex_mode_r;
    q_item.is_digit    = (in_ch >= CH_ZERO) && (in_ch <= CH_NINE);
    q_item.is_nib      = q_item.is_digit || is_lo || is_up;
    if (q_item.is_digit) begin
      q_item.nib = off_d[3:0];
    end else if (is_lo) begin
      q_item.nib = off_l[3:0] + 4'd10;
    end else begin
      q_item.nib = off_u[3:0] + 4'd10;
    end
    q_item.is_minus = (in_ch == CH_MINUS);
    q_item.is_zero  = (in_ch == CH_ZERO);
    q_item.is_x     = (in_ch == CH_X);
  end

endmodule
`default_nettype wire

@@ sv/cip_queue.sv @@
// Two-entry queue of classified character requests between front and back.
// Uses cip_pkg for the entry type.
`default_nettype none
module cip_queue
  import cip_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire cip_item_t push_item,
  output logic           full,
  input  wire logic      pop,
  output logic           not_empty,
  output cip_item_t      head
);

  cip_item_t  entry_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = entry_r[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

@@ sv/cip_exec.sv @@
// Execute stage: folds each character into the token state and hands a
// token summary to the finish stage when the token ends. Uses cip_pkg.
`default_nettype none
module cip_exec
  import cip_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      q_valid,
  input  wire cip_item_t q_item,
  output logic           q_pop,
  output logic           fin_valid,
  input  wire logic      fin_ready,
  output cip_fin_t       fin
);

  logic [63:0] acc_r,  acc_nxt,  acc_upd;
  logic [1:0]  pos_r,  pos_nxt,  pos_upd;
  logic        neg_r,  neg_nxt,  neg_upd;
  logic        inv_r,  inv_nxt,  inv_upd;
  logic        ovf_r,  ovf_nxt,  ovf_upd;
  logic [4:0]  hcnt_r, hcnt_nxt, hcnt_upd;
  logic        pf_r,   pf_nxt,   pf_upd;
  logic        fin_valid_r, fin_valid_nxt;
  cip_fin_t    fin_r, fin_nxt;
  logic        ends;
  logic [67:0] dec_sum;

  assign fin_valid = fin_valid_r;
  assign fin       = fin_r;

  // Pop unless a token end finds the summary slot still occupied
  assign ends  = q_item.last || q_item.empty;
  assign q_pop = q_valid && (!ends || !fin_valid_r || fin_ready);

  // Multiply by ten as shift-add, plus the digit
  assign dec_sum = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {64'd0, q_item.nib};

  // Fold one character into the token state
  always_comb begin
    acc_upd  = acc_r;
    pos_upd  = pos_r;
    neg_upd  = neg_r;
    inv_upd  = inv_r;
    ovf_upd  = ovf_r;
    hcnt_upd = hcnt_r;
    pf_upd   = pf_r;
    if (q_item.hex) begin
      if (pos_r == 2'd0) begin
        if (!q_item.is_zero) pf_upd = 1'b1;
      end else if (pos_r == 2'd1) begin
        if (!q_item.is_x) pf_upd = 1'b1;
      end else begin
        if (hcnt_r < HCNT_MAX) hcnt_upd = hcnt_r + 5'd1;
        if (!q_item.is_nib) begin
          inv_upd = 1'b1;
        end else begin
          acc_upd = {acc_r[59:0], q_item.nib};
        end
      end
    end else begin
      if (pos_r == 2'd0 && q_item.is_minus) begin
        neg_upd = 1'b1;
      end else if (q_item.is_digit) begin
        if (!ovf_r) begin
          if (dec_sum[67:64] != 4'd0) begin
            ovf_upd = 1'b1;
          end else begin
            acc_upd = dec_sum[63:0];
          end
        end
      end else begin
        inv_upd = 1'b1;
      end
    end
    if (pos_r != POS_MAX) pos_upd = pos_r + 2'd1;
  end

  // Commit state, clear at token end and build the summary
  always_comb begin
    acc_nxt  = acc_r;
    pos_nxt  = pos_r;
    neg_nxt  = neg_r;
    inv_nxt  = inv_r;
    ovf_nxt  = ovf_r;
    hcnt_nxt = hcnt_r;
    pf_nxt   = pf_r;
    fin_nxt  = fin_r;
    fin_valid_nxt = fin_valid_r && !fin_ready;
    if (q_pop) begin
      if (ends) begin
        acc_nxt  = 64'd0;
        pos_nxt  = 2'd0;
        neg_nxt  = 1'b0;
        inv_nxt  = 1'b0;
        ovf_nxt  = 1'b0;
        hcnt_nxt = 5'd0;
        pf_nxt   = 1'b0;
        fin_valid_nxt       = 1'b1;
        fin_nxt.empty       = q_item.empty;
        fin_nxt.hex         = q_item.hex;
        fin_nxt.width_code  = q_item.width_code;
        fin_nxt.signed_type = q_item.signed_type;
        fin_nxt.acc         = acc_upd;
        fin_nxt.pos         = pos_upd;
        fin_nxt.neg         = neg_upd;
        fin_nxt.inv         = inv_upd;
        fin_nxt.ovf         = ovf_upd;
        fin_nxt.hcnt        = hcnt_upd;
        fin_nxt.pfault      = pf_upd;
      end else begin
        acc_nxt  = acc_upd;
        pos_nxt  = pos_upd;
        neg_nxt  = neg_upd;
        inv_nxt  = inv_upd;
        ovf_nxt  = ovf_upd;
        hcnt_nxt = hcnt_upd;
        pf_nxt   = pf_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= 64'd0;
      pos_r       <= 2'd0;
      neg_r       <= 1'b0;
      inv_r       <= 1'b0;
      ovf_r       <= 1'b0;
      hcnt_r      <= 5'd0;
      pf_r        <= 1'b0;
      fin_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      pos_r       <= pos_nxt;
      neg_r       <= neg_nxt;
      inv_r       <= inv_nxt;
      ovf_r       <= ovf_nxt;
      hcnt_r      <= hcnt_nxt;
      pf_r        <= pf_nxt;
      fin_valid_r <= fin_valid_nxt;
    end
  end

  // Hold the summary payload
  always_ff @(posedge clk) begin
    fin_r <= fin_nxt;
  end

endmodule
`default_nettype wire

@@ sv/cip_finish.sv @@
// Finish stage: range-checks a token summary, picks the status and value,
// and holds the result in the output register. Uses cip_pkg.
`default_nettype none
module cip_finish
  import cip_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        fin_valid,
  output logic             fin_ready,
  input  wire cip_fin_t    fin,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_value,
  output logic [2:0]       out_status
);

  logic        out_valid_r, out_valid_nxt;
  logic [63:0] value_r, value_nxt;
  logic [2:0]  status_r, status_nxt;
  logic [63:0] umax;
  logic [63:0] smax;
  logic [63:0] smin_mag;
  logic        above_umax;
  logic        above_smax;
  logic        take;

  assign out_valid  = out_valid_r;
  assign out_value  = value_r;
  assign out_status = status_r;

  // Load a new result when the output register is free or draining
  assign fin_ready = !out_valid_r || out_ready;
  assign take      = fin_valid && fin_ready;

  // Range checks and status precedence
  always_comb begin
    umax       = cip_umax(fin.width_code);
    smax       = {1'b0, umax[63:1]};
    smin_mag   = umax ^ smax;
    above_umax = (fin.acc & ~umax) != 64'd0;
    above_smax = (fin.acc & ~smax) != 64'd0;
    value_nxt  = 64'd0;
    if (fin.empty) begin
      status_nxt = ST_EMPTY;
    end else if (fin.hex) begin
      if (fin.pfault || fin.pos < 2'd2) begin
        status_nxt = ST_INVALID;
      end else if (fin.hcnt > cip_hex_limit(fin.width_code)) begin
        status_nxt = ST_OVERFLOW;
      end else if (fin.inv) begin
        status_nxt = ST_INVALID;
      end else begin
        status_nxt = ST_OK;
        value_nxt  = fin.acc & umax;
      end
    end else if (fin.inv || (fin.neg && !fin.signed_type)) begin
      status_nxt = ST_INVALID;
    end else if (fin.ovf || above_umax) begin
      status_nxt = ST_OVERFLOW;
    end else if (fin.signed_type && fin.neg) begin
      if (above_smax && fin.acc != smin_mag) begin
        status_nxt = ST_UNDERFLOW;
      end else begin
        status_nxt = ST_OK;
        value_nxt  = (64'd0 - fin.acc) & umax;
      end
    end else if (fin.signed_type && above_smax) begin
      status_nxt = ST_OVERFLOW;
    end else begin
      status_nxt = ST_OK;
      value_nxt  = fin.acc;
    end
  end

  assign out_valid_nxt = take || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the result payload until it is taken
  always_ff @(posedge clk) begin
    if (take) begin
      value_r  <= value_nxt;
      status_r <= status_nxt;
    end
  end

endmodule
`default_nettype wire

@@ sv/checked_integer_text_parser.sv @@
// Top level of the checked integer text parser: front end, request queue,
// execute stage and finish stage. Uses cip_pkg and the cip_* modules.
//
//   Channel  Handshake              Payload
//   cfg      cfg_valid/cfg_ready    cfg_hex_mode
//   in       in_valid/in_ready      in_ch, in_last_char, in_empty_token,
//                                   in_width_code, in_signed_type
//   out      out_valid/out_ready    out_value, out_status
//
// One character request per cycle while the queue has room; the execute
// stage's 64-bit multiply-by-ten shift-add sets the cycle time. The request that
// ends a token passes the queue, then the summary and output registers.
// Reset (rst_n low, synchronous) clears the mode, token state and all valids.
// A stalled output fills the summary slot and then the two-entry queue
// before in_ready drops.
`default_nettype none
module checked_integer_text_parser
  import cip_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_hex_mode,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_ch,
  input  wire logic        in_last_char,
  input  wire logic        in_empty_token,
  input  wire logic [1:0]  in_width_code,
  input  wire logic        in_signed_type,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_value,
  output logic [2:0]       out_status
);

  logic      q_full;
  logic      q_push;
  cip_item_t q_in;
  logic      q_pop;
  logic      q_valid;
  cip_item_t q_head;
  logic      fin_valid;
  logic      fin_ready;
  cip_fin_t  fin;

  cip_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_hex_mode   (cfg_hex_mode),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_ch          (in_ch),
    .in_last_char   (in_last_char),
    .in_empty_token (in_empty_token),
    .in_width_code  (in_width_code),
    .in_signed_type (in_signed_type),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (q_in)
  );

  cip_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  cip_exec u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_head),
    .q_pop     (q_pop),
    .fin_valid (fin_valid),
    .fin_ready (fin_ready),
    .fin       (fin)
  );

  cip_finish u_finish (
    .clk        (clk),
    .rst_n      (rst_n),
    .fin_valid  (fin_valid),
    .fin_ready  (fin_ready),
    .fin        (fin),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_value  (out_value),
    .out_status (out_status)
  );

endmodule
`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for checked_integer_text_parser: directed and random
// ASCII tokens checked against a built-in parse predictor. Depends on cip_pkg.
`default_nettype none
module tb
  import cip_pkg::*;
();

  typedef struct packed {
    logic [63:0] value;
    logic [2:0]  status;
  } parse_result_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_hex_mode;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_ch;
  logic        in_last_char;
  logic        in_empty_token;
  logic [1:0]  in_width_code;
  logic        in_signed_type;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_value;
  logic [2:0]  out_status;

  // Predicted results in request order, and the predictor's token state
  parse_result_t pending_parses[$];
  logic          mode_hex;
  logic [63:0]   tok_acc;
  logic [1:0]    tok_pos;
  logic          tok_neg;
  logic          tok_bad_char;
  logic          tok_wrapped;
  logic [4:0]    tok_hex_digits;
  logic          tok_bad_prefix;

  // Stimulus control shared between the sender and the receiver
  logic [7:0] token_buf[$];
  int         items_sent;
  int         mismatches;
  int         hold_cycles;
  logic       send_burst;
  logic       recv_burst;
  logic       mix_controls;

  checked_integer_text_parser dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_hex_mode  (cfg_hex_mode),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_ch         (in_ch),
    .in_last_char  (in_last_char),
    .in_empty_token(in_empty_token),
    .in_width_code (in_width_code),
    .in_signed_type(in_signed_type),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_value     (out_value),
    .out_status    (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #800000;
    $display("[checked_integer_text_parser] ERROR");
    $finish;
  end

  // Drop all per-token state
  function automatic void clear_token();
    tok_acc        = 64'd0;
    tok_pos        = 2'd0;
    tok_neg        = 1'b0;
    tok_bad_char   = 1'b0;
    tok_wrapped    = 1'b0;
    tok_hex_digits = 5'd0;
    tok_bad_prefix = 1'b0;
  endfunction

  // Resolve a finished token against the target width and signedness
  function automatic parse_result_t token_outcome(input logic [1:0] wc, input logic sgn);
    int            bits;
    logic [63:0]   umax;
    logic [63:0]   smax;
    parse_result_t r;
    bits     = 8 << wc;
    umax     = ~64'd0 >> (64 - bits);
    smax     = umax >> 1;
    r.value  = 64'd0;
    r.status = ST_OK;
    if (mode_hex) begin
      if (tok_bad_prefix || tok_pos < 2'd2) r.status = ST_INVALID;
      else if (tok_hex_digits > bits / 4) r.status = ST_OVERFLOW;
      else if (tok_bad_char) r.status = ST_INVALID;
      else r.value = tok_acc & umax;
    end else if (tok_bad_char || (tok_neg && !sgn)) begin
      r.status = ST_INVALID;
    end else if (tok_wrapped || tok_acc > umax) begin
      r.status = ST_OVERFLOW;
    end else if (sgn && tok_neg) begin
      if (tok_acc > smax + 64'd1) r.status = ST_UNDERFLOW;
      else r.value = (64'd0 - tok_acc) & umax;
    end else if (sgn && tok_acc > smax) begin
      r.status = ST_OVERFLOW;
    end else begin
      r.value = tok_acc;
    end
    return r;
  endfunction

  // Advance the predictor by one accepted character request
  task automatic predict_char(input logic [7:0] ch, input logic last, input logic empty,
                              input logic [1:0] wc, input logic sgn);
    logic [63:0]   d;
    logic [7:0]    t;
    logic          nib_ok;
    parse_result_t r;
    if (empty) begin
      clear_token();
      r.value  = 64'd0;
      r.status = ST_EMPTY;
      pending_parses.push_back(r);
    end else begin
      if (mode_hex) begin
        if (tok_pos == 2'd0) begin
          if (ch != CH_ZERO) tok_bad_prefix = 1'b1;
        end else if (tok_pos == 2'd1) begin
          if (ch != CH_X) tok_bad_prefix = 1'b1;
        end else begin
          nib_ok = 1'b1;
          t      = 8'd0;
          if (ch >= CH_ZERO && ch <= CH_NINE) t = ch - CH_ZERO;
          else if (ch >= CH_LA && ch <= CH_LF) t = ch - CH_LA + 8'd10;
          else if (ch >= CH_UA && ch <= CH_UF) t = ch - CH_UA + 8'd10;
          else nib_ok = 1'b0;
          if (tok_hex_digits < HCNT_MAX) tok_hex_digits = tok_hex_digits + 5'd1;
          if (!nib_ok) tok_bad_char = 1'b1;
          else tok_acc = {tok_acc[59:0], t[3:0]};
        end
      end else begin
        if (tok_pos == 2'd0 && ch == CH_MINUS) begin
          tok_neg = 1'b1;
        end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
          d = {56'd0, ch - CH_ZERO};
          if (!tok_wrapped) begin
            if (tok_acc > (~64'd0 - d) / 64'd10) tok_wrapped = 1'b1;
            else tok_acc = tok_acc * 64'd10 + d;
          end
        end else begin
          tok_bad_char = 1'b1;
        end
      end
      if (tok_pos < POS_MAX) tok_pos = tok_pos + 2'd1;
      if (last) begin
        r = token_outcome(wc, sgn);
        clear_token();
        pending_parses.push_back(r);
      end
    end
  endtask

  // Count a failure; report only the first few
  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  // Receive results, compare each with the oldest prediction, draw stalls
  initial begin : result_checker
    int            stall_left;
    parse_result_t want;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_parses.size() == 0) begin
          note_mismatch($sformatf("unexpected result: value %h status %0d",
                                  out_value, out_status));
        end else begin
          want = pending_parses.pop_front();
          if (out_value !== want.value || out_status !== want.status)
            note_mismatch($sformatf(
              "result mismatch: expected value %h status %0d, got value %h status %0d",
              want.value, want.status, out_value, out_status));
        end
        stall_left = recv_burst ? 0 : $urandom_range(0, 12);
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offer one character request and hold it until accepted
  task automatic offer_char(input logic [7:0] ch, input logic last, input logic empty,
                            input logic [1:0] wc, input logic sgn);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch          <= ch;
    in_last_char   <= last;
    in_empty_token <= empty;
    in_width_code  <= wc;
    in_signed_type <= sgn;
    in_valid       <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_char(ch, last, empty, wc, sgn);
    items_sent++;
  endtask

  // Send token_buf as one token; an empty buffer becomes an empty-token request
  task automatic send_token(input logic [1:0] wc, input logic sgn);
    int         i;
    logic [1:0] w;
    logic       s;
    if (token_buf.size() == 0) begin
      offer_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1, wc, sgn);
    end else begin
      for (i = 0; i < token_buf.size(); i++) begin
        w = wc;
        s = sgn;
        // Controls on inner characters should not matter
        if (mix_controls && i != token_buf.size() - 1 && $urandom_range(0, 3) == 0) begin
          w = 2'($urandom_range(0, 3));
          s = 1'($urandom_range(0, 1));
        end
        offer_char(token_buf[i], i == token_buf.size() - 1, 1'b0, w, s);
      end
    end
  endtask

  task automatic parse_text(input string s, input logic [1:0] wc, input logic sgn);
    int i;
    token_buf.delete();
    for (i = 0; i < s.len(); i++) token_buf.push_back(s[i]);
    send_token(wc, sgn);
  endtask

  // Wait until every predicted result is in, then let in-flight requests settle
  task automatic wait_parses_done();
    if (in_valid) in_valid <= 1'b0;
    while (pending_parses.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_hex_mode(input logic m);
    wait_parses_done();
    cfg_hex_mode <= m;
    cfg_valid    <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mode_hex = m;
  endtask

  // Token builders: each fills token_buf
  task automatic build_decimal(input logic sgn);
    int n;
    int i;
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 21) : $urandom_range(1, 6);
    token_buf.delete();
    if (sgn && $urandom_range(0, 2) == 0) token_buf.push_back(CH_MINUS);
    for (i = 0; i < n; i++) token_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  // Decimal value near a range limit of the target, or a random value in range
  task automatic build_decimal_edge(input logic [1:0] wc, input logic sgn);
    int          bits;
    int          delta;
    int          i;
    logic [63:0] umax;
    logic [63:0] v;
    string       s;
    bits = 8 << wc;
    umax = ~64'd0 >> (64 - bits);
    case ($urandom_range(0, 4))
      0:       v = 64'd0;
      1:       v = umax >> 1;
      2:       v = (umax >> 1) + 64'd1;
      3:       v = umax;
      default: v = {$urandom, $urandom} & umax;
    endcase
    delta = int'($urandom_range(0, 6)) - 3;
    if (delta < 0) v = v - 64'(-delta);
    else v = v + 64'(delta);
    s = $sformatf("%0d", v);
    token_buf.delete();
    if (sgn && $urandom_range(0, 1) == 1) token_buf.push_back(CH_MINUS);
    for (i = 0; i < s.len(); i++) token_buf.push_back(s[i]);
    // Append an extra digit now and then
    if ($urandom_range(0, 9) == 0) token_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task automatic build_hex(input logic [1:0] wc, input logic full);
    int n;
    int k;
    int i;
    int bits;
    bits = 8 << wc;
    n    = full ? bits / 4 : $urandom_range(0, bits / 4 + 1);
    if (!full && $urandom_range(0, 9) == 0) n = $urandom_range(0, 18);
    token_buf.delete();
    token_buf.push_back(CH_ZERO);
    token_buf.push_back(CH_X);
    for (i = 0; i < n; i++) begin
      k = $urandom_range(0, 21);
      if (k < 10) token_buf.push_back(CH_ZERO + 8'(k));
      else if (k < 16) token_buf.push_back(CH_LA + 8'(k - 10));
      else token_buf.push_back(CH_UA + 8'(k - 16));
    end
  endtask

  task automatic build_noise();
    int n;
    int i;
    n = $urandom_range(1, 6);
    token_buf.delete();
    for (i = 0; i < n; i++) token_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic test_decimal_edges();
    parse_text("0", WC_8, 1'b0);
    parse_text("255", WC_8, 1'b0);
    parse_text("256", WC_8, 1'b0);
    parse_text("-128", WC_8, 1'b1);
    parse_text("-129", WC_8, 1'b1);
    parse_text("128", WC_8, 1'b1);
    parse_text("-", WC_16, 1'b1);
    parse_text("-7", WC_32, 1'b0);
    parse_text("4-2", WC_16, 1'b1);
    parse_text("-99999", WC_8, 1'b1);
    parse_text("12a", WC_8, 1'b0);
    parse_text("18446744073709551615", WC_64, 1'b0);
    parse_text("18446744073709551616", WC_64, 1'b0);
    parse_text("-9223372036854775808", WC_64, 1'b1);
    parse_text("", WC_8, 1'b0);
    // Abandon a partial token with an empty-token request
    offer_char(CH_ZERO + 8'd3, 1'b0, 1'b0, WC_8, 1'b0);
    offer_char(8'hFF, 1'b1, 1'b1, WC_8, 1'b0);
  endtask

  task automatic test_hex_edges();
    write_hex_mode(1'b1);
    parse_text("0xff", WC_8, 1'b0);
    parse_text("0x", WC_16, 1'b0);
    parse_text("0xFFFFFFFFFFFFFFFF", WC_64, 1'b0);
    parse_text("0x1ff", WC_8, 1'b0);
    parse_text("0xzz9", WC_8, 1'b0);
    parse_text("0xg1", WC_32, 1'b0);
    parse_text("0", WC_8, 1'b0);
    parse_text("1x5", WC_8, 1'b0);
    parse_text("0X5", WC_8, 1'b0);
    parse_text("0x80", WC_8, 1'b1);
    parse_text("0xAbCd8000", WC_32, 1'b1);
    parse_text("", WC_64, 1'b1);
  endtask

  // Flip the mode between characters of one token
  task automatic test_mode_switch_mid_token();
    write_hex_mode(1'b0);
    offer_char(CH_ZERO + 8'd1, 1'b0, 1'b0, WC_8, 1'b0);
    write_hex_mode(1'b1);
    offer_char(CH_X, 1'b0, 1'b0, WC_8, 1'b0);
    offer_char(CH_ZERO + 8'd5, 1'b1, 1'b0, WC_8, 1'b0);
    offer_char(CH_ZERO, 1'b0, 1'b0, WC_16, 1'b0);
    offer_char(CH_X, 1'b0, 1'b0, WC_16, 1'b0);
    write_hex_mode(1'b0);
    offer_char(CH_ZERO + 8'd7, 1'b1, 1'b0, WC_16, 1'b1);
  endtask

  // Hold the receiver off while the sender keeps pushing, then drain
  task automatic test_backpressure();
    int i;
    hold_cycles = 300;
    send_burst  = 1'b1;
    for (i = 0; i < 80; i++) begin
      token_buf.delete();
      if (mode_hex) build_hex(WC_8, 1'b0);
      else token_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      send_token(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    end
    send_burst = 1'b0;
    wait_parses_done();
  endtask

  task automatic random_traffic_phase(input int n_chars);
    int         start;
    int         kind;
    logic [1:0] wc;
    logic       sgn;
    start = items_sent;
    while (items_sent - start < n_chars) begin
      if ($urandom_range(0, 49) == 0) begin
        send_burst = ($urandom_range(0, 3) == 0);
        recv_burst = ($urandom_range(0, 3) == 0);
      end
      wc   = 2'($urandom_range(0, 3));
      sgn  = 1'($urandom_range(0, 1));
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        if (mode_hex) build_hex(wc, 1'b0);
        else build_decimal(sgn);
      end else if (kind < 65) begin
        if (mode_hex) build_hex(wc, 1'b1);
        else build_decimal_edge(wc, sgn);
      end else if (kind < 80) begin
        // Corrupt one character of a good token
        if (mode_hex) build_hex(wc, 1'b0);
        else build_decimal(sgn);
        token_buf[$urandom_range(0, token_buf.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (kind < 86) begin
        build_decimal(1'b1);
      end else if (kind < 94) begin
        build_noise();
      end else begin
        token_buf.delete();
      end
      send_token(wc, sgn);
    end
  endtask

  task automatic test_random_traffic();
    int p;
    mix_controls = 1'b1;
    for (p = 0; p < 4; p++) begin
      write_hex_mode(p[0]);
      random_traffic_phase(440);
    end
    mix_controls = 1'b0;
    send_burst   = 1'b0;
    recv_burst   = 1'b0;
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_valid      = 1'b0;
    cfg_hex_mode   = 1'b0;
    in_valid       = 1'b0;
    in_ch          = 8'd0;
    in_last_char   = 1'b0;
    in_empty_token = 1'b0;
    in_width_code  = WC_8;
    in_signed_type = 1'b0;
    mode_hex       = 1'b0;
    items_sent     = 0;
    mismatches     = 0;
    hold_cycles    = 0;
    send_burst     = 1'b0;
    recv_burst     = 1'b0;
    mix_controls   = 1'b0;
    clear_token();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_decimal_edges();
    test_hex_edges();
    test_mode_switch_mid_token();
    test_backpressure();
    test_random_traffic();

    wait_parses_done();
    repeat (12) @(posedge clk);
    if (mismatches == 0 && pending_parses.size() == 0) begin
      $display("[checked_integer_text_parser] OK");
    end else begin
      $display("[checked_integer_text_parser] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
